FILE: rtl/g5ge_pkg.sv
// ----------------------------------------------------------------------------
// g5ge_pkg
// Shared types and constants of the 5x5 Gaussian blur / gradient edge block.
// ----------------------------------------------------------------------------
package g5ge_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  localparam int CFG_W    = 12;   // size register width
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 11;   // out_col / out_row width
  localparam int SLOT_W   = 3;    // eight line slots
  localparam int ACC_W    = 17;   // 255 * 273 fits
  localparam int SQ_W     = 17;   // gx^2 + gy^2 fits
  localparam int ROOT_W   = 9;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;

  // floor(acc / 273) == (acc * 122911) >> 25 for every acc up to 255 * 273
  localparam logic [16:0] DIV_MUL   = 17'd122911;
  localparam int          DIV_SHIFT = 25;

  // configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [5:0] GAUSS_K [25] = '{
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd7, 6'd26, 6'd41, 6'd26, 6'd7,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] value;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

endpackage

FILE: rtl/g5ge_ram.sv
// ----------------------------------------------------------------------------
// g5ge_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module g5ge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/g5ge_isqrt.sv
// ----------------------------------------------------------------------------
// g5ge_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module g5ge_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  g5ge_pkg::root_req_t req,
  output g5ge_pkg::root_rsp_t rsp
);

  localparam int RW = g5ge_pkg::SQ_W + 1;

  logic [RW-1:0] v;
  logic [RW-1:0] r;
  logic [RW-1:0] bitv;
  logic          busy;
  logic          done;
  logic [RW-1:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        v    <= RW'(req.value);
        r    <= '0;
        bitv <= RW'(1) << (g5ge_pkg::SQ_W - 1);
      end else if (busy) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == RW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = r[g5ge_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/gauss5x5_gradient_edge_top.sv
// ----------------------------------------------------------------------------
// gauss5x5_gradient_edge_top
// 5x5 Gaussian blur, central-difference gradient and magnitude on a pixel
// stream, with clamp-replicated borders.
// ----------------------------------------------------------------------------
// One request is handled at a time. A pixel request is written into an
// eight-line raw pixel RAM in the cycle it is accepted. If the next result is
// then due, the block reads the 100 raw pixels behind the four blurred
// neighbors through the single RAM read port, one a cycle, divides each blur
// sum by 273, squares the differences and takes the root in a bit-serial
// unit. A request that yields no result goes from ST_CHECK back to ST_IDLE;
// one that yields a result runs through the read, flush, square, sum, root and
// output states plus any wait on m_tready. After the frame's last pixel the
// host sends drain requests (tuser = 1) until the result with tlast comes
// out. Writing a size register restarts the frame; sizes of zero act as 1,
// sizes above MAX_WIDTH / MAX_HEIGHT act as that maximum. The result register
// holds a finished result while the next request is accepted.
module gauss5x5_gradient_edge_top #(
  parameter int MAX_WIDTH  = g5ge_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = g5ge_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] pixel
  input  logic        s_tuser,    // [0] cmd (0 pixel, 1 drain)
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [7:0] edge_res, [18:8] out_col, [29:19] out_row
  output logic        m_tlast,    // frame_last
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,  // 0 image_width, 1 image_height
  input  logic [11:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);   // column counter
  localparam int RW = $clog2(MAX_HEIGHT);  // row counter
  localparam int WW = CW + 1;              // effective width
  localparam int HW = RW + 1;              // effective height
  localparam int AW = g5ge_pkg::SLOT_W + CW;
  localparam int SX = CW + 3;              // signed tap column
  localparam int SY = RW + 3;              // signed tap row

  function automatic logic [WW-1:0] eff_w_f(input logic [g5ge_pkg::CFG_W-1:0] v);
    if (v == '0) return WW'(1);
    if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] eff_h_f(input logic [g5ge_pkg::CFG_W-1:0] v);
    if (v == '0) return HW'(1);
    if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  g5ge_pkg::state_t state, state_next;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [CW-1:0] in_col;
  logic [RW-1:0] in_line;
  logic [CW-1:0] emit_col;
  logic [RW-1:0] emit_line;
  logic          finished;

  logic          accept;
  logic          store_pix;
  logic          due;

  // tap sequencer
  logic [1:0]    bsel;
  logic [2:0]    ti;
  logic [2:0]    tj;
  logic          last_tap;

  // read / accumulate pipeline
  logic                        rd_v;
  logic [5:0]                  wt_d;
  logic                        endb_d;
  logic [1:0]                  b_d;
  logic [g5ge_pkg::ACC_W-1:0]  acc;
  logic [g5ge_pkg::ACC_W-1:0]  acc_sum;
  logic [g5ge_pkg::ACC_W-1:0]  div_in;
  logic                        div_go;
  logic [1:0]                  div_b;
  logic [33:0]                 div_prod;
  logic [7:0]                  blur [4];

  logic [16:0]                 sqx;
  logic [16:0]                 sqy;
  logic signed [8:0]           gx;
  logic signed [8:0]           gy;
  logic [7:0]                  mag;

  // RAM ports
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;
  logic [7:0]                  rdata;

  g5ge_pkg::root_req_t         root_req;
  g5ge_pkg::root_rsp_t         root_rsp;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == g5ge_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign store_pix = accept && (s_tuser == g5ge_pkg::CMD_PIXEL) && !finished;
  assign waddr     = {in_line[g5ge_pkg::SLOT_W-1:0], in_col};

  g5ge_ram #(
    .WIDTH (g5ge_pkg::PIX_W),
    .DEPTH (8 << CW)
  ) u_raw_ram (
    .clk   (clk),
    .we    (store_pix),
    .waddr (waddr),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Is the next result due? (last needed pixel received or frame done)
  logic [HW:0] rn;
  logic [WW:0] cn;
  always_comb begin
    logic [HW:0] e3y;
    logic [HW:0] hm1;
    logic [WW:0] e3x;
    logic [WW:0] wm1;
    e3y = (HW+1)'(emit_line) + (HW+1)'(3);
    hm1 = (HW+1)'(eff_h) - (HW+1)'(1);
    e3x = (WW+1)'(emit_col) + (WW+1)'(3);
    wm1 = (WW+1)'(eff_w) - (WW+1)'(1);
    rn  = (e3y < hm1) ? e3y : hm1;
    cn  = (e3x < wm1) ? e3x : wm1;
    due = finished || ((HW+1)'(in_line) > rn) ||
          (((HW+1)'(in_line) == rn) && ((WW+1)'(in_col) > cn));
  end

  // Tap address with border clamp
  always_comb begin
    logic signed [3:0]    offx;
    logic signed [3:0]    offy;
    logic signed [SX-1:0] x;
    logic signed [SY-1:0] y;
    logic [CW-1:0]        cx;
    logic [RW-1:0]        cy;
    offx = $signed({1'b0, ti}) - 4'sd2;
    offy = $signed({1'b0, tj}) - 4'sd2;
    case (bsel)
      2'd0:    offx = offx + 4'sd1;
      2'd1:    offx = offx - 4'sd1;
      2'd2:    offy = offy + 4'sd1;
      default: offy = offy - 4'sd1;
    endcase
    x = $signed(SX'(emit_col)) + SX'(offx);
    y = $signed(SY'(emit_line)) + SY'(offy);
    if (x < 0) begin
      cx = '0;
    end else if (x >= $signed(SX'(eff_w))) begin
      cx = CW'(eff_w - WW'(1));
    end else begin
      cx = x[CW-1:0];
    end
    if (y < 0) begin
      cy = '0;
    end else if (y >= $signed(SY'(eff_h))) begin
      cy = RW'(eff_h - HW'(1));
    end else begin
      cy = y[RW-1:0];
    end
    raddr = {cy[g5ge_pkg::SLOT_W-1:0], cx};
  end

  assign last_tap = (ti == 3'd4) && (tj == 3'd4) && (bsel == 2'd3);
  assign acc_sum  = acc + g5ge_pkg::ACC_W'(rdata * wt_d);
  assign div_prod = div_in * g5ge_pkg::DIV_MUL;

  assign gx = $signed({1'b0, blur[0]}) - $signed({1'b0, blur[1]});
  assign gy = $signed({1'b0, blur[2]}) - $signed({1'b0, blur[3]});

  assign root_req.start = (state == g5ge_pkg::ST_SUM);
  assign root_req.value = sqx + sqy;

  g5ge_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      g5ge_pkg::ST_IDLE:   if (accept) state_next = g5ge_pkg::ST_CHECK;
      g5ge_pkg::ST_CHECK:  state_next = due ? g5ge_pkg::ST_READ : g5ge_pkg::ST_IDLE;
      g5ge_pkg::ST_READ:   if (last_tap) state_next = g5ge_pkg::ST_FLUSH1;
      g5ge_pkg::ST_FLUSH1: state_next = g5ge_pkg::ST_FLUSH2;
      g5ge_pkg::ST_FLUSH2: state_next = g5ge_pkg::ST_SQUARE;
      g5ge_pkg::ST_SQUARE: state_next = g5ge_pkg::ST_SUM;
      g5ge_pkg::ST_SUM:    state_next = g5ge_pkg::ST_ROOT;
      g5ge_pkg::ST_ROOT:   if (root_rsp.done) state_next = g5ge_pkg::ST_OUT;
      g5ge_pkg::ST_OUT:    if (!m_tvalid || m_tready) state_next = g5ge_pkg::ST_IDLE;
      default:             state_next = g5ge_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= g5ge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // frame counters, config, result register
  logic out_last;
  assign out_last = ((WW'(emit_col) + WW'(1)) >= eff_w) &&
                    ((HW'(emit_line) + HW'(1)) >= eff_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w     <= eff_w_f(g5ge_pkg::RESET_WIDTH);
      eff_h     <= eff_h_f(g5ge_pkg::RESET_HEIGHT);
      in_col    <= '0;
      in_line   <= '0;
      emit_col  <= '0;
      emit_line <= '0;
      finished  <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // load a new result, else clear on handshake
      if (state == g5ge_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          g5ge_pkg::REG_IMAGE_WIDTH:  eff_w <= eff_w_f(cfg_data);
          g5ge_pkg::REG_IMAGE_HEIGHT: eff_h <= eff_h_f(cfg_data);
          default:                    eff_w <= eff_w;
        endcase
        in_col    <= '0;
        in_line   <= '0;
        emit_col  <= '0;
        emit_line <= '0;
        finished  <= 1'b0;
      end else if (store_pix) begin
        if ((WW'(in_col) + WW'(1)) >= eff_w) begin
          in_col <= '0;
          if ((HW'(in_line) + HW'(1)) >= eff_h) begin
            in_line  <= '0;
            finished <= 1'b1;
          end else begin
            in_line <= in_line + RW'(1);
          end
        end else begin
          in_col <= in_col + CW'(1);
        end
      end else if (state == g5ge_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
        if (out_last) begin
          emit_col  <= '0;
          emit_line <= '0;
          finished  <= 1'b0;
        end else if ((WW'(emit_col) + WW'(1)) >= eff_w) begin
          emit_col  <= '0;
          emit_line <= emit_line + RW'(1);
        end else begin
          emit_col <= emit_col + CW'(1);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == g5ge_pkg::ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {2'b00, 11'(32'(emit_line)), 11'(32'(emit_col)), mag};
      m_tlast <= out_last;
    end
  end

  // tap sequencer and accumulate / divide pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      bsel   <= '0;
      ti     <= '0;
      tj     <= '0;
      rd_v   <= 1'b0;
      div_go <= 1'b0;
      acc    <= '0;
    end else begin
      rd_v   <= (state == g5ge_pkg::ST_READ);
      div_go <= 1'b0;
      if (state == g5ge_pkg::ST_READ) begin
        wt_d   <= g5ge_pkg::GAUSS_K[5'(tj) * 5'd5 + 5'(ti)];
        endb_d <= (ti == 3'd4) && (tj == 3'd4);
        b_d    <= bsel;
        if (ti == 3'd4) begin
          ti <= '0;
          if (tj == 3'd4) begin
            tj   <= '0;
            bsel <= bsel + 2'd1;
          end else begin
            tj <= tj + 3'd1;
          end
        end else begin
          ti <= ti + 3'd1;
        end
      end
      if (rd_v) begin
        if (endb_d) begin
          acc    <= '0;
          div_in <= acc_sum;
          div_b  <= b_d;
          div_go <= 1'b1;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_go) begin
      blur[div_b] <= div_prod[g5ge_pkg::DIV_SHIFT+7:g5ge_pkg::DIV_SHIFT];
    end
    if (state == g5ge_pkg::ST_SQUARE) begin
      sqx <= 17'(gx * gx);
      sqy <= 17'(gy * gy);
    end
    if (state == g5ge_pkg::ST_ROOT && root_rsp.done) begin
      mag <= (root_rsp.root > 9'd255) ? 8'd255 : root_rsp.root[7:0];
    end
  end

endmodule

FILE: tb/sv/gauss5x5_gradient_edge_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss5x5_gradient_edge_top_test
// Self-checking bench for the Gaussian blur / gradient edge block: a queued
// driver and a monitor check every result against a cycle-free edge predictor
// over small frames, partial frames at the size extremes and drain handling.
// ----------------------------------------------------------------------------
module gauss5x5_gradient_edge_top_test;

  localparam int HALF_PERIOD = 4;
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES = 600;    // long receiver hold-off
  localparam int ITEM_GOAL   = 950;

  // idling modes of both stream sides
  typedef enum int {MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH} idle_mode_t;

  typedef struct {
    logic       cmd;
    logic [7:0] pixel;
  } pixel_req_t;

  typedef struct {
    logic [7:0]  edge_res;
    logic [10:0] col;
    logic [10:0] row;
    logic        last;
  } edge_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = g5ge_pkg::REG_IMAGE_WIDTH;
  logic [11:0] cfg_data = '0;

  gauss5x5_gradient_edge_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: its own copy of the size registers, counters and the
  // eight-line pixel store.
  // --------------------------------------------------------------------------
  logic [11:0] width_reg  = g5ge_pkg::RESET_WIDTH;
  logic [11:0] height_reg = g5ge_pkg::RESET_HEIGHT;
  logic [7:0]  line_mem [8][2048];
  int          pix_col, pix_row, res_col, res_row;
  bit          draining;

  pixel_req_t  pixel_q [$];   // requests waiting for the driver
  edge_res_t   edge_q  [$];   // predicted results, oldest first
  idle_mode_t  idle_mode = MODE_FREE;
  bit          hold_req  = 1'b0;
  int          errors    = 0;
  int          items     = 0;

  function automatic int eff_size(logic [11:0] v);
    if (v == 0) return 1;
    return (v > 2048) ? 2048 : int'(v);
  endfunction

  function automatic int clampi(int c, int size);
    if (c < 0) return 0;
    return (c >= size) ? size - 1 : c;
  endfunction

  // 5x5 Gaussian at (x,y) with replicated borders, floor-divided by 273
  function automatic int blurred(int x, int y);
    int acc;
    int w;
    int h;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    acc = 0;
    for (int j = -2; j <= 2; j++)
      for (int i = -2; i <= 2; i++)
        acc += int'(g5ge_pkg::GAUSS_K[(j + 2) * 5 + i + 2]) *
               int'(line_mem[clampi(y + j, h) % 8][clampi(x + i, w)]);
    return acc / 273;
  endfunction

  function automatic int root_floor(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Apply one accepted request; queue a result if one becomes due.
  function automatic void apply_request(logic cmd, logic [7:0] pixel);
    int w;
    int h;
    int rn;
    int cn;
    int gx;
    int gy;
    int mag;
    bit due;
    edge_res_t r;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    // pixels arriving while draining act as drains
    if (cmd == g5ge_pkg::CMD_PIXEL && !draining) begin
      line_mem[pix_row % 8][pix_col] = pixel;
      pix_col++;
      if (pix_col >= w) begin
        pix_col = 0;
        pix_row++;
        if (pix_row >= h) begin
          pix_row  = 0;
          draining = 1'b1;
        end
      end
    end
    if (draining) due = 1'b1;
    else begin
      rn  = (res_row + 3 < h - 1) ? res_row + 3 : h - 1;
      cn  = (res_col + 3 < w - 1) ? res_col + 3 : w - 1;
      due = pix_row > rn || (pix_row == rn && pix_col > cn);
    end
    if (!due) return;
    gx  = blurred(res_col + 1, res_row) - blurred(res_col - 1, res_row);
    gy  = blurred(res_col, res_row + 1) - blurred(res_col, res_row - 1);
    mag = root_floor(gx * gx + gy * gy);
    r.edge_res = (mag > 255) ? 8'd255 : mag[7:0];
    r.col      = res_col[10:0];
    r.row      = res_row[10:0];
    r.last     = (res_col + 1 >= w && res_row + 1 >= h);
    edge_q.push_back(r);
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
    end
    if (r.last) begin
      res_col  = 0;
      res_row  = 0;
      draining = 1'b0;
    end
  endfunction

  function automatic void restart_frame();
    pix_col  = 0;
    pix_row  = 0;
    res_col  = 0;
    res_row  = 0;
    draining = 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: holds a request until accepted, gaps chosen by the idling mode.
  // --------------------------------------------------------------------------
  function automatic bit src_offers();
    case (idle_mode)
      MODE_SRC_IDLE: return $urandom_range(99) >= 86;
      MODE_BOTH:     return $urandom_range(99) >= 6;
      default:       return 1'b1;
    endcase
  endfunction

  always @(posedge clk) begin : drv
    bit         taken;
    bit         next_valid;
    pixel_req_t req;
    if (!rst) begin
      taken = s_tvalid && s_tready;
      if (taken) apply_request(s_tuser, s_tdata);
      next_valid = s_tvalid && !taken;
      if (!next_valid && pixel_q.size() > 0 && src_offers()) begin
        req = pixel_q.pop_front();
        s_tdata    <= req.pixel;
        s_tuser    <= req.cmd;
        next_valid = 1'b1;
      end
      s_tvalid <= next_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure plus one long hold-off on request.
  // --------------------------------------------------------------------------
  int hold_left = 0;

  always @(posedge clk) begin : mon
    edge_res_t e;
    bit        rdy;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (edge_q.size() == 0) begin
          $error("result with nothing expected: col %0d row %0d",
                 m_tdata[18:8], m_tdata[29:19]);
          errors++;
        end else begin
          e = edge_q.pop_front();
          if (m_tdata[7:0] !== e.edge_res) begin
            $error("edge_res: expected %0d, got %0d", e.edge_res, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[18:8] !== e.col) begin
            $error("out_col: expected %0d, got %0d", e.col, m_tdata[18:8]);
            errors++;
          end
          if (m_tdata[29:19] !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, m_tdata[29:19]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("frame_last: expected %0d, got %0d", e.last, m_tlast);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left <= HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        case (idle_mode)
          MODE_SNK_STALL: rdy = $urandom_range(99) >= 86;
          MODE_BOTH:      rdy = $urandom_range(99) >= 6;
          default:        rdy = 1'b1;
        endcase
      end
      m_tready <= rdy;
    end
  end

  // Watchdog: any handshake counts as progress.
  int quiet = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else if (quiet >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else
        quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push(logic cmd, logic [7:0] pixel);
    pixel_req_t r;
    r.cmd   = cmd;
    r.pixel = pixel;
    pixel_q.push_back(r);
    items++;
  endtask

  // All requests taken and all results in, checked at the falling edge once
  // the driver has settled; then a wait on the clock so that a request that
  // yields no result has left the block.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pixel_q.size() != 0 || s_tvalid || edge_q.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == g5ge_pkg::REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    restart_frame();
  endtask

  task automatic set_size(logic [11:0] w, logic [11:0] h);
    wait_quiet();
    write_reg(g5ge_pkg::REG_IMAGE_WIDTH, w);
    write_reg(g5ge_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // Feed drains one at a time while the frame is draining; optionally one
  // pixel request first, which must act as a drain.
  task automatic drain_frame(bit stray_pixel);
    forever begin
      do @(negedge clk);
      while (pixel_q.size() != 0 || s_tvalid);
      if (!draining) break;
      if (stray_pixel) begin
        push(g5ge_pkg::CMD_PIXEL, 8'($urandom));
        stray_pixel = 1'b0;
      end else
        push(g5ge_pkg::CMD_DRAIN, 8'($urandom));
    end
  endtask

  initial begin : stim
    int w;
    int h;
    int n;
    int style;
    int frame_no;
    restart_frame();
    foreach (line_mem[s, c]) line_mem[s][c] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // default 640x480: a few pixels, none yields a result yet
    for (int i = 0; i < 6; i++) push(g5ge_pkg::CMD_PIXEL, 8'($urandom));

    // zero sizes act as 1: a 1x1 frame finishes on its only pixel
    set_size(12'd0, 12'd0);
    push(g5ge_pkg::CMD_PIXEL, 8'd255);
    push(g5ge_pkg::CMD_DRAIN, 8'd0);            // nothing ready

    // 5x4 step pattern at the pixel extremes, drain before anything is due
    set_size(12'd5, 12'd4);
    push(g5ge_pkg::CMD_DRAIN, 8'hA5);
    for (int y = 0; y < 4; y++)
      for (int x = 0; x < 5; x++)
        push(g5ge_pkg::CMD_PIXEL, (x >= 2 && y >= 2) ? 8'd255 : 8'd0);
    drain_frame(1'b1);

    // oversize width, partial frame abandoned by the next size write
    set_size(12'd4095, 12'd1);
    for (int i = 0; i < 40; i++) push(g5ge_pkg::CMD_PIXEL, 8'($urandom));
    set_size(12'd1, 12'd4095);
    for (int i = 0; i < 30; i++) push(g5ge_pkg::CMD_PIXEL, 8'($urandom));
    set_size(12'd2048, 12'd2048);
    for (int i = 0; i < 12; i++) push(g5ge_pkg::CMD_PIXEL, 8'($urandom));

    // random frames
    frame_no = 0;
    while (items < ITEM_GOAL) begin
      wait_quiet();
      idle_mode = idle_mode_t'((frame_no / 2) % 4);
      w = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      h = $urandom_range(10, 1);
      // the hold-off frame is big enough to back up the input
      if (frame_no == 3) begin
        w = 12;
        h = 6;
      end
      write_reg(g5ge_pkg::REG_IMAGE_WIDTH, 12'(w));
      write_reg(g5ge_pkg::REG_IMAGE_HEIGHT, 12'(h));
      if (frame_no == 3) hold_req = 1'b1;   // receiver holds off, input backs up
      style = $urandom_range(3);
      n = w * h;
      if (frame_no != 3 && $urandom_range(7) == 0) n = $urandom_range(w * h);  // broken
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(15) == 0) push(g5ge_pkg::CMD_DRAIN, 8'($urandom));
        case (style)
          0:       push(g5ge_pkg::CMD_PIXEL, $urandom_range(1) ? 8'd255 : 8'd0);
          1:       push(g5ge_pkg::CMD_PIXEL,
                        ((i % w) > w / 2) ? 8'd255 : 8'($urandom_range(20)));
          default: push(g5ge_pkg::CMD_PIXEL, 8'($urandom));
        endcase
      end
      if (n == w * h) drain_frame($urandom_range(3) == 0);
      frame_no++;
    end

    wait_quiet();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/g5ge_pkg.sv
rtl/g5ge_ram.sv
rtl/g5ge_isqrt.sv
rtl/gauss5x5_gradient_edge_top.sv
tb/sv/gauss5x5_gradient_edge_top_test.sv
